[rtl/phtp_pkg.sv]
// shared types, constants and field helpers for the pes header timestamp parser
`timescale 1ns / 1ps

package phtp_pkg;

	// byte positions inside a pes packet
	localparam logic [8:0] POS_STREAM_ID = 9'd3;
	localparam logic [8:0] POS_LEN_HI    = 9'd4;
	localparam logic [8:0] POS_LEN_LO    = 9'd5;
	localparam logic [8:0] POS_FLAGS     = 9'd7;
	localparam logic [8:0] POS_HDR_LEN   = 9'd8;
	localparam logic [8:0] POS_OPT_START = 9'd9;
	localparam logic [8:0] POS_MAX       = 9'd511;

	// stream ids that carry no optional header
	localparam logic [7:0] SID_PROGRAM_MAP  = 8'hbc;
	localparam logic [7:0] SID_PADDING      = 8'hbe;
	localparam logic [7:0] SID_PRIVATE_2    = 8'hbf;
	localparam logic [7:0] SID_ECM          = 8'hf0;
	localparam logic [7:0] SID_EMM          = 8'hf1;
	localparam logic [7:0] SID_DIRECTORY    = 8'hff;
	localparam logic [7:0] SID_DSMCC        = 8'hf2;
	localparam logic [7:0] SID_H222_TYPE_E  = 8'hf8;

	// optional field sizes in bytes
	localparam logic [4:0] TS_FIELD_BYTES   = 5'd5;
	localparam logic [4:0] ESCR_FIELD_BYTES = 5'd6;
	localparam logic [4:0] RATE_FIELD_BYTES = 5'd3;
	localparam logic [16:0] PKT_LEN_OVERHEAD = 17'd3;

	// reciprocals of 9: ceil(2^21/9) for 17-bit and ceil(2^24/9) for 20-bit dividends
	localparam logic [17:0] DIV9_HI_MUL = 18'd233017;
	localparam logic [20:0] DIV9_LO_MUL = 21'd1864136;

	typedef struct packed {
		logic [7:0]  pes_id;
		logic        header_present;
		logic [1:0]  pts_dts_mode;
		logic [32:0] pts;
		logic [32:0] dts;
		logic        escr_present;
		logic        rate_present;
		logic [7:0]  header_data_len;
		logic [15:0] payload_len;
		logic        payload_len_known;
		logic        header_overrun;
	} res_fields_t;

	typedef struct packed {
		res_fields_t f;
		logic [36:0] time_us;
	} out_item_t;

	function automatic logic id_has_no_header(input logic [7:0] sid);
		return (sid == SID_PROGRAM_MAP) || (sid == SID_PADDING) || (sid == SID_PRIVATE_2) ||
			(sid == SID_ECM) || (sid == SID_EMM) || (sid == SID_DIRECTORY) ||
			(sid == SID_DSMCC) || (sid == SID_H222_TYPE_E);
	endfunction

	// merge byte k of a 5-byte timestamp field, marker bits dropped
	function automatic logic [32:0] merge_ts(input logic [32:0] acc, input logic [2:0] k,
			input logic [7:0] b);
		logic [32:0] r;
		r = acc;
		case (k)
			3'd0: r[32:30] = r[32:30] | b[3:1];
			3'd1: r[29:22] = r[29:22] | b;
			3'd2: r[21:15] = r[21:15] | b[7:1];
			3'd3: r[14:7]  = r[14:7] | b;
			3'd4: r[6:0]   = r[6:0] | b[7:1];
			default: r = acc;
		endcase
		return r;
	endfunction

endpackage

[rtl/phtp_time_scale.sv]
// pipelined scaling of a 90 kHz tick difference to microseconds: d*100/9
`timescale 1ns / 1ps

module phtp_time_scale import phtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  res_fields_t in_item,
	input  logic [32:0] in_diff,
	output logic        out_valid,
	output res_fields_t out_item,
	output logic [36:0] out_time
);

	// 100*d/9 = 11*d + d/9, and d/9 is split at bit 16 into two reciprocal multiplies
	logic [16:0] dh;
	logic [34:0] prod_h;
	logic [36:0] mul11;

	logic        v_s2;
	res_fields_t item_s2;
	logic [36:0] a_s2;
	logic [13:0] qh_s2;
	logic [16:0] dh_s2;
	logic [15:0] dl_s2;

	logic [16:0] rem_full;
	logic [3:0]  rh;
	logic [19:0] x_lo;
	logic [40:0] prod_l;

	logic        v_s3;
	res_fields_t item_s3;
	logic [36:0] part_s3;
	logic [15:0] ql_s3;

	assign dh     = in_diff[32:16];
	assign prod_h = 35'(dh) * 35'(DIV9_HI_MUL);
	assign mul11  = {1'b0, in_diff, 3'b000} + {3'b000, in_diff, 1'b0} + {4'b0000, in_diff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= in_item;
			a_s2    <= mul11;
			qh_s2   <= prod_h[34:21];
			dh_s2   <= dh;
			dl_s2   <= in_diff[15:0];
		end
	end

	// remainder of the high part is below 9
	assign rem_full = dh_s2 - ({qh_s2, 3'b000} + 17'(qh_s2));
	assign rh       = rem_full[3:0];
	assign x_lo     = {rh, dl_s2};
	assign prod_l   = 41'(x_lo) * 41'(DIV9_LO_MUL);

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3 <= item_s2;
			part_s3 <= a_s2 + {7'd0, qh_s2, 16'd0};
			ql_s3   <= prod_l[39:24];
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;
	assign out_time  = part_s3 + 37'(ql_s3);

endmodule

[rtl/pes_header_timestamp_parser.sv]
// top level: pes byte parser, timestamp scaling pipeline and output skid stage
`timescale 1ns / 1ps

// Takes one PES byte per transfer (s_tuser marks the first byte of a packet) and
// gives at most one result per packet: on byte 5 for header-less stream ids,
// otherwise on the last byte of the optional header. A byte is taken every cycle
// while s_tready is high; each byte updates the field registers in the cycle it
// arrives, and its result passes the s1, s2 and s3 stages that turn the PTS
// difference into microseconds, then the output register. s_tready drops only
// while both the output and the skid register hold results m_tready has not taken.
module pes_header_timestamp_parser import phtp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,  // data_byte
	input  logic          s_tuser,  // packet_start
	output logic          m_tvalid,
	input  logic          m_tready,
	// pes_id, pts_dts_mode, pts, dts, escr_present, rate_present,
	// header_data_len, payload_len, payload_len_known, time_us, header_overrun, zero pad
	output logic [143:0]  m_tdata,
	output logic          m_tuser   // header_present
);

	logic in_fire;
	logic adv;

	logic [8:0]  pos_q;
	logic        active_q;
	logic        reported_q;
	logic [7:0]  sid_q;
	logic [15:0] len_q;
	logic [3:0]  flags_q;
	logic [7:0]  hlen_q;
	logic [32:0] pts_q;
	logic [32:0] dts_q;
	logic        first_v_q;
	logic [32:0] first_q;

	logic [8:0]  c_pos;
	logic        c_reported;
	logic [8:0]  n_pos;
	logic        n_active;
	logic        n_reported;
	logic [7:0]  n_sid;
	logic [15:0] n_len;
	logic [3:0]  n_flags;
	logic [7:0]  n_hlen;
	logic [32:0] n_pts;
	logic [32:0] n_dts;
	logic        n_first_v;
	logic [32:0] n_first;
	logic [1:0]  mode;
	logic [8:0]  k;
	logic [8:0]  kd;
	logic [4:0]  need;
	logic [7:0]  span;
	logic [16:0] len_sub;
	logic [32:0] pts_eff;
	logic        res_v;
	res_fields_t res;
	logic [32:0] diff;

	logic        res_v_s1;
	res_fields_t res_s1;
	logic [32:0] diff_s1;

	logic        ts_valid;
	res_fields_t ts_item;
	logic [36:0] ts_time;

	logic        out_v_q;
	out_item_t   out_q;
	logic        skid_v_q;
	out_item_t   skid_q;
	out_item_t   ts_out;

	assign s_tready = !skid_v_q;
	assign adv      = !skid_v_q;
	assign in_fire  = s_tvalid && s_tready;

	always_comb begin
		c_pos      = s_tuser ? 9'd0 : pos_q;
		c_reported = s_tuser ? 1'b0 : reported_q;
		n_active   = s_tuser | active_q;
		n_reported = c_reported;
		n_pos      = (c_pos < POS_MAX) ? c_pos + 9'd1 : c_pos;
		n_sid      = s_tuser ? 8'd0 : sid_q;
		n_len      = s_tuser ? 16'd0 : len_q;
		n_flags    = s_tuser ? 4'd0 : flags_q;
		n_hlen     = s_tuser ? 8'd0 : hlen_q;
		n_pts      = s_tuser ? 33'd0 : pts_q;
		n_dts      = s_tuser ? 33'd0 : dts_q;
		n_first_v  = first_v_q;
		n_first    = first_q;
		k          = c_pos - POS_OPT_START;
		kd         = k - 9'(TS_FIELD_BYTES);
		res_v      = 1'b0;
		res        = '0;
		diff       = 33'd0;
		need       = 5'd0;
		span       = 8'd0;
		len_sub    = 17'd0;
		pts_eff    = 33'd0;
		mode       = n_flags[3:2];

		if (n_active && !c_reported) begin
			if (c_pos == POS_STREAM_ID) begin
				n_sid = s_tdata;
			end else if (c_pos == POS_LEN_HI) begin
				n_len = {s_tdata, 8'd0};
			end else if (c_pos == POS_LEN_LO) begin
				n_len = {n_len[15:8], s_tdata};
			end else if (c_pos == POS_FLAGS) begin
				n_flags = s_tdata[7:4];
			end else if (c_pos == POS_HDR_LEN) begin
				n_hlen = s_tdata;
			end else if (c_pos >= POS_OPT_START) begin
				if (n_flags[3] && k < 9'(TS_FIELD_BYTES))
					n_pts = merge_ts(n_pts, k[2:0], s_tdata);
				if ((&n_flags[3:2]) && k >= 9'(TS_FIELD_BYTES) && kd < 9'(TS_FIELD_BYTES))
					n_dts = merge_ts(n_dts, kd[2:0], s_tdata);
			end
			mode = n_flags[3:2];

			need = (mode[1] ? TS_FIELD_BYTES : 5'd0) + ((&mode) ? TS_FIELD_BYTES : 5'd0) +
				(n_flags[1] ? ESCR_FIELD_BYTES : 5'd0) + (n_flags[0] ? RATE_FIELD_BYTES : 5'd0);
			span = (n_hlen > 8'(need)) ? n_hlen : 8'(need);
			len_sub = PKT_LEN_OVERHEAD + 17'(n_hlen);

			if (c_pos == POS_LEN_LO && id_has_no_header(n_sid)) begin
				res_v                 = 1'b1;
				res.pes_id            = n_sid;
				res.payload_len       = n_len;
				res.payload_len_known = (n_len != 16'd0);
			end else if (c_pos >= POS_HDR_LEN && c_pos == POS_HDR_LEN + 9'(span)) begin
				res_v   = 1'b1;
				pts_eff = mode[1] ? n_pts : 33'd0;
				if (!first_v_q) begin
					n_first_v = 1'b1;
					n_first   = pts_eff;
				end else if (pts_eff >= first_q) begin
					diff = pts_eff - first_q;
				end
				res.pes_id            = n_sid;
				res.header_present    = 1'b1;
				res.pts_dts_mode      = mode;
				res.pts               = pts_eff;
				res.dts               = (&mode) ? n_dts : 33'd0;
				res.escr_present      = n_flags[1];
				res.rate_present      = n_flags[0];
				res.header_data_len   = n_hlen;
				res.payload_len_known = (n_len != 16'd0);
				if (n_len != 16'd0 && {1'b0, n_len} >= len_sub)
					res.payload_len = 16'({1'b0, n_len} - len_sub);
				res.header_overrun    = (8'(need) > n_hlen);
			end
			n_reported = res_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 9'd0;
			active_q   <= 1'b0;
			reported_q <= 1'b0;
			sid_q      <= 8'd0;
			len_q      <= 16'd0;
			flags_q    <= 4'd0;
			hlen_q     <= 8'd0;
			pts_q      <= 33'd0;
			dts_q      <= 33'd0;
			first_v_q  <= 1'b0;
			first_q    <= 33'd0;
			res_v_s1   <= 1'b0;
		end else begin
			if (in_fire) begin
				pos_q      <= n_pos;
				active_q   <= n_active;
				reported_q <= n_reported;
				sid_q      <= n_sid;
				len_q      <= n_len;
				flags_q    <= n_flags;
				hlen_q     <= n_hlen;
				pts_q      <= n_pts;
				dts_q      <= n_dts;
				first_v_q  <= n_first_v;
				first_q    <= n_first;
			end
			if (adv)
				res_v_s1 <= in_fire && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s1  <= res;
			diff_s1 <= diff;
		end
	end

	phtp_time_scale u_time_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (res_v_s1),
		.in_item   (res_s1),
		.in_diff   (diff_s1),
		.out_valid (ts_valid),
		.out_item  (ts_item),
		.out_time  (ts_time)
	);

	assign ts_out.f       = ts_item;
	assign ts_out.time_us = ts_time;

	// output register with a skid register behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= ts_valid;
			end
		end else if (ts_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (ts_valid)
				out_q <= ts_out;
		end else if (ts_valid && !skid_v_q) begin
			skid_q <= ts_out;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.f.header_present;
	assign m_tdata  = {3'b000, out_q.f.header_overrun, out_q.time_us,
		out_q.f.payload_len_known, out_q.f.payload_len, out_q.f.header_data_len,
		out_q.f.rate_present, out_q.f.escr_present, out_q.f.dts, out_q.f.pts,
		out_q.f.pts_dts_mode, out_q.f.pes_id};

	// skid register is only filled behind a waiting output
	assert property (@(posedge clk) disable iff (!arst_n) skid_v_q |-> out_v_q)
		else $error("skid holds a result while output register is empty");

	// a reported packet ignores the rest of its bytes
	assert property (@(posedge clk) disable iff (!arst_n) (in_fire && res_v) |=> reported_q)
		else $error("packet not marked reported after its result");

	// first pts is only cleared by reset
	assert property (@(posedge clk) disable iff (!arst_n) first_v_q |=> first_v_q)
		else $error("first pts reference lost");

	// header-less results carry no timing
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_q.f.header_present) |-> (out_q.time_us == 37'd0 && out_q.f.pts == 33'd0))
		else $error("header-less result with nonzero time");

	// unknown length always reports zero payload
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_q.f.payload_len_known) |-> (out_q.f.payload_len == 16'd0))
		else $error("payload length nonzero for unbounded packet");

endmodule

[verif/tb_pes_header_timestamp_parser.sv]
// testbench for the pes header timestamp parser: packet stimulus, byte-level predictor, checker
`timescale 1ns / 1ps

module tb_pes_header_timestamp_parser import phtp_pkg::*; ();

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 300;

	typedef logic [7:0] bytes_t [$];

	logic          clk;
	logic          arst_n   = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [7:0]    s_tdata  = 8'h00;
	logic          s_tuser  = 1'b0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [143:0]  m_tdata;
	logic          m_tuser;

	// stimulus knobs
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_reqs      = 0;
	int holds_done     = 0;
	int hold_left      = 0;
	int bytes_sent     = 0;
	int errors         = 0;
	int cycle_count    = 0;

	logic [7:0] plain_ids [8] = '{SID_PROGRAM_MAP, SID_PADDING, SID_PRIVATE_2, SID_ECM,
		SID_EMM, SID_DIRECTORY, SID_DSMCC, SID_H222_TYPE_E};

	// predictor state
	logic [8:0]  pos;
	logic        in_pkt;
	logic        pkt_done;
	logic [7:0]  cur_sid;
	logic [15:0] cur_plen;
	logic [3:0]  cur_flags;
	logic [7:0]  cur_hlen;
	logic [32:0] pts_acc;
	logic [32:0] dts_acc;
	logic        have_first_pts;
	logic [32:0] first_pts;

	out_item_t pending_reports [$];
	out_item_t chk_want;
	out_item_t chk_got;

	pes_header_timestamp_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic is_plain_id(input logic [7:0] sid);
		return sid inside {SID_PROGRAM_MAP, SID_PADDING, SID_PRIVATE_2, SID_ECM, SID_EMM,
			SID_DIRECTORY, SID_DSMCC, SID_H222_TYPE_E};
	endfunction

	// bytes taken by the optional fields that the flag nibble announces
	function automatic int field_bytes(input logic [3:0] flg);
		int n;
		n = 0;
		if (flg[3]) n += 5;
		if (flg[3:2] == 2'b11) n += 5;
		if (flg[1]) n += 6;
		if (flg[0]) n += 3;
		return n;
	endfunction

	function automatic logic [32:0] ts_merge(input logic [32:0] acc, input int k,
			input logic [7:0] b);
		case (k)
			0: acc[32:30] = acc[32:30] | b[3:1];
			1: acc[29:22] = acc[29:22] | b;
			2: acc[21:15] = acc[21:15] | b[7:1];
			3: acc[14:7]  = acc[14:7] | b;
			4: acc[6:0]   = acc[6:0] | b[7:1];
			default: ;
		endcase
		return acc;
	endfunction

	task automatic clear_packet_state();
		pos       = '0;
		pkt_done  = 1'b0;
		cur_sid   = '0;
		cur_plen  = '0;
		cur_flags = '0;
		cur_hlen  = '0;
		pts_acc   = '0;
		dts_acc   = '0;
	endtask

	// follows one accepted byte and queues the report it completes, if any
	task automatic parse_byte(input logic [7:0] b, input logic st);
		int p, k, need, span, pl;
		logic [1:0] mode;
		logic [32:0] pv, dv, diff;
		logic [39:0] scaled;
		out_item_t rep;
		if (st) begin
			clear_packet_state();
			in_pkt = 1'b1;
		end
		if (in_pkt && !pkt_done) begin
			p = int'(pos);
			if (p == POS_STREAM_ID) cur_sid = b;
			else if (p == POS_LEN_HI) cur_plen = {b, 8'h00};
			else if (p == POS_LEN_LO) cur_plen = cur_plen | {8'h00, b};
			else if (p == POS_FLAGS) cur_flags = b[7:4];
			else if (p == POS_HDR_LEN) cur_hlen = b;
			else if (p >= POS_OPT_START) begin
				k = p - POS_OPT_START;
				if (cur_flags[3] && k < 5) pts_acc = ts_merge(pts_acc, k, b);
				if (cur_flags[3:2] == 2'b11 && k >= 5 && k < 10)
					dts_acc = ts_merge(dts_acc, k - 5, b);
			end
			mode = cur_flags[3:2];
			need = field_bytes(cur_flags);
			span = (int'(cur_hlen) > need) ? int'(cur_hlen) : need;
			rep = '0;
			if (p == POS_LEN_LO && is_plain_id(cur_sid)) begin
				rep.f.pes_id = cur_sid;
				rep.f.payload_len = cur_plen;
				rep.f.payload_len_known = (cur_plen != 0);
				pending_reports.push_back(rep);
				pkt_done = 1'b1;
			end else if (p == POS_HDR_LEN + span) begin
				pv = mode[1] ? pts_acc : 33'd0;
				dv = (mode == 2'b11) ? dts_acc : 33'd0;
				if (!have_first_pts) begin
					have_first_pts = 1'b1;
					first_pts = pv;
					diff = '0;
				end else if (pv < first_pts) begin
					diff = '0;
				end else begin
					diff = pv - first_pts;
				end
				scaled = {7'd0, diff} * 40'd100 / 40'd9;
				pl = int'(cur_plen);
				rep.f.pes_id = cur_sid;
				rep.f.header_present = 1'b1;
				rep.f.pts_dts_mode = mode;
				rep.f.pts = pv;
				rep.f.dts = dv;
				rep.f.escr_present = cur_flags[1];
				rep.f.rate_present = cur_flags[0];
				rep.f.header_data_len = cur_hlen;
				rep.f.payload_len = (pl != 0 && pl >= 3 + cur_hlen) ? 16'(pl - 3 - cur_hlen) : 16'd0;
				rep.f.payload_len_known = (pl != 0);
				rep.f.header_overrun = (need > cur_hlen);
				rep.time_us = scaled[36:0];
				pending_reports.push_back(rep);
				pkt_done = 1'b1;
			end
		end
		if (pos < POS_MAX) pos = pos + 9'd1;
	endtask

	task automatic send_byte(input logic [7:0] d, input logic st);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= st;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		parse_byte(d, st);
	endtask

	task automatic send_pkt(ref bytes_t q, input int keep);
		for (int i = 0; i < keep; i++) send_byte(q[i], i == 0);
	endtask

	task automatic send_tail(input int n);
		repeat (n) send_byte(8'($urandom), 1'b0);
	endtask

	task automatic make_plain_pkt(ref bytes_t q, input logic [7:0] sid, input logic [15:0] plen);
		q.delete();
		repeat (3) q.push_back(8'($urandom));
		q.push_back(sid);
		q.push_back(plen[15:8]);
		q.push_back(plen[7:0]);
	endtask

	// 5-byte timestamp field, marker and prefix bits random
	function automatic logic [39:0] ts_field(input logic [32:0] v);
		logic [7:0] r;
		r = 8'($urandom);
		return {r[7:4], v[32:30], r[0], v[29:22], v[21:15], r[1], v[14:7], v[6:0], r[2]};
	endfunction

	task automatic make_header_pkt(ref bytes_t q, input logic [7:0] sid, input logic [15:0] plen,
			input logic [3:0] flg, input logic [7:0] hlen, input logic [32:0] pts,
			input logic [32:0] dts);
		int need, span;
		logic [39:0] f;
		make_plain_pkt(q, sid, plen);
		q.push_back(8'($urandom));
		q.push_back({flg, 4'($urandom)});
		q.push_back(hlen);
		need = field_bytes(flg);
		span = (int'(hlen) > need) ? int'(hlen) : need;
		repeat (span) q.push_back(8'($urandom));
		if (flg[3]) begin
			f = ts_field(pts);
			for (int k = 0; k < 5; k++) q[POS_OPT_START + k] = f[39 - 8 * k -: 8];
		end
		if (flg[3:2] == 2'b11) begin
			f = ts_field(dts);
			for (int k = 0; k < 5; k++) q[POS_OPT_START + 5 + k] = f[39 - 8 * k -: 8];
		end
	endtask

	function automatic logic [32:0] rand_ts();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 33'($urandom_range(2000));
			default: return w[32:0];
		endcase
	endfunction

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_packet();
		bytes_t q;
		logic [7:0] sid, hlen;
		logic [15:0] plen;
		logic [3:0] flg;
		int r, need, keep;
		r = $urandom_range(99);
		if (r < 5) begin
			// noise: stray bytes, some of them marked as packet starts
			repeat ($urandom_range(1, 20)) send_byte(8'($urandom), $urandom_range(99) < 20);
		end else begin
			if (r < 20) begin
				sid = plain_ids[$urandom_range(7)];
				hlen = '0;
			end else begin
				do sid = 8'($urandom); while (is_plain_id(sid));
				flg = 4'($urandom);
				need = field_bytes(flg);
				r = $urandom_range(99);
				if (r < 60) hlen = 8'(need + $urandom_range(3));
				else if (r < 80) hlen = 8'($urandom_range(need));
				else if (r < 97) hlen = 8'($urandom_range(40));
				else hlen = 8'($urandom);
			end
			r = $urandom_range(99);
			if (r < 10) plen = '0;
			else if (r < 20) plen = '1;
			else if (r < 50) plen = 16'(hlen + $urandom_range(6));
			else plen = 16'($urandom);
			if (is_plain_id(sid)) make_plain_pkt(q, sid, plen);
			else make_header_pkt(q, sid, plen, flg, hlen, rand_ts(), rand_ts());
			if ($urandom_range(99) < 10) begin
				keep = $urandom_range(1, q.size() - 1);
				send_pkt(q, keep);
			end else begin
				send_pkt(q, q.size());
				send_tail($urandom_range(4));
			end
		end
	endtask

	task automatic test_plain_ids();
		bytes_t q;
		logic [15:0] plen;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// nothing counts before the first packet start
		send_tail(4);
		foreach (plain_ids[i]) begin
			case (i % 3)
				0: plen = '0;
				1: plen = '1;
				default: plen = 16'($urandom);
			endcase
			make_plain_pkt(q, plain_ids[i], plen);
			send_pkt(q, q.size());
		end
		drain();
	endtask

	task automatic test_header_fields();
		bytes_t q;
		// first header packet after reset sets the time origin
		make_header_pkt(q, 8'he0, 16'h0000, 4'b1000, 8'd5, 33'd1000, 33'd0);
		send_pkt(q, q.size());
		make_header_pkt(q, 8'hc0, 16'hffff, 4'b1111, 8'd19, '1, 33'd0);
		send_pkt(q, q.size());
		// no pts, id zero, payload exactly used up
		make_header_pkt(q, 8'h00, 16'd3, 4'b0000, 8'd0, 33'd0, 33'd0);
		send_pkt(q, q.size());
		// longest header with a short length, tail runs the position past its ceiling
		make_header_pkt(q, 8'hfe, 16'd100, 4'b0100, 8'd255, 33'd0, 33'd0);
		send_pkt(q, q.size());
		send_tail(260);
		// flagged fields overrun an empty header, pts behind the origin
		make_header_pkt(q, 8'hbd, 16'd40, 4'b1111, 8'd0, 33'd999, '1);
		send_pkt(q, q.size());
		// packet cut inside its pts, then one nine ticks after the origin
		make_header_pkt(q, 8'he1, 16'd500, 4'b1100, 8'd10, 33'd5, 33'd6);
		send_pkt(q, 11);
		make_header_pkt(q, 8'he2, 16'd13, 4'b1100, 8'd10, 33'd1009, 33'd77);
		send_pkt(q, q.size());
		drain();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int nbytes);
		int start;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = bytes_sent;
		while (bytes_sent - start < nbytes) send_random_packet();
		drain();
	endtask

	// receiver holds off while short packets keep coming, so the input must stall
	task automatic test_backpressure();
		bytes_t q;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk) hold_reqs++;
		@(posedge clk);
		repeat (20) begin
			make_plain_pkt(q, plain_ids[$urandom_range(7)], 16'($urandom));
			send_pkt(q, q.size());
		end
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_reqs != holds_done) begin
			hold_left = HOLD_CYCLES;
			holds_done = hold_reqs;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] seen);
		if (want !== seen) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: result transfer with none pending, got %h", $time, m_tdata);
			end else begin
				chk_want = pending_reports.pop_front();
				chk_got.f.pes_id            = m_tdata[7:0];
				chk_got.f.header_present    = m_tuser;
				chk_got.f.pts_dts_mode      = m_tdata[9:8];
				chk_got.f.pts               = m_tdata[42:10];
				chk_got.f.dts               = m_tdata[75:43];
				chk_got.f.escr_present      = m_tdata[76];
				chk_got.f.rate_present      = m_tdata[77];
				chk_got.f.header_data_len   = m_tdata[85:78];
				chk_got.f.payload_len       = m_tdata[101:86];
				chk_got.f.payload_len_known = m_tdata[102];
				chk_got.time_us             = m_tdata[139:103];
				chk_got.f.header_overrun    = m_tdata[140];
				check_field("pes_id", 64'(chk_want.f.pes_id), 64'(chk_got.f.pes_id));
				check_field("header_present", 64'(chk_want.f.header_present),
					64'(chk_got.f.header_present));
				check_field("pts_dts_mode", 64'(chk_want.f.pts_dts_mode),
					64'(chk_got.f.pts_dts_mode));
				check_field("pts", 64'(chk_want.f.pts), 64'(chk_got.f.pts));
				check_field("dts", 64'(chk_want.f.dts), 64'(chk_got.f.dts));
				check_field("escr_present", 64'(chk_want.f.escr_present),
					64'(chk_got.f.escr_present));
				check_field("rate_present", 64'(chk_want.f.rate_present),
					64'(chk_got.f.rate_present));
				check_field("header_data_len", 64'(chk_want.f.header_data_len),
					64'(chk_got.f.header_data_len));
				check_field("payload_len", 64'(chk_want.f.payload_len),
					64'(chk_got.f.payload_len));
				check_field("payload_len_known", 64'(chk_want.f.payload_len_known),
					64'(chk_got.f.payload_len_known));
				check_field("time_us", 64'(chk_want.time_us), 64'(chk_got.time_us));
				check_field("header_overrun", 64'(chk_want.f.header_overrun),
					64'(chk_got.f.header_overrun));
				check_field("pad", 64'd0, 64'(m_tdata[143:141]));
			end
		end
	end

	initial begin
		clear_packet_state();
		in_pkt = 1'b0;
		have_first_pts = 1'b0;
		first_pts = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_plain_ids();
		test_header_fields();
		test_random_traffic(0, 0, 100);
		test_random_traffic(66, 0, 100);
		test_random_traffic(0, 66, 100);
		test_random_traffic(34, 34, 100);
		test_backpressure();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/phtp_pkg.sv
rtl/phtp_time_scale.sv
rtl/pes_header_timestamp_parser.sv
verif/tb_pes_header_timestamp_parser.sv
